[src/bbg_pkg.sv]
// Shared types and constants for the 3x3 grey box blur.
`timescale 1ns / 1ps

package bbg_pkg;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int POS_W  = 10;
  localparam int CFG_W  = 11;
  localparam int SUM_W  = 12;   // nine 8-bit pixels fit in 12 bits
  localparam int LINE_W = 2 * PIX_W;  // one entry holds {row r-2, row r-1}

  // Default line length and reset value of the size register
  localparam int MAX_SIZE_DEF = 1024;
  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd256;
  localparam int MIN_SIZE = 3;

  // Divide by nine: floor(sum * 7282 / 2^16) is exact for sum < 2296
  localparam int RECIP_W  = 13;
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
  localparam int RECIP_SH = 16;
  localparam int PROD_W   = SUM_W + RECIP_W;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // One result item
  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic [POS_W-1:0] center_row;
    logic [POS_W-1:0] center_col;
    logic             last_of_frame;
  } res_t;

  // Control and payload of the item in the read-modify-write stage
  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             last;
    logic [PIX_W-1:0] px;
    logic [POS_W-1:0] center_row;
    logic [POS_W-1:0] center_col;
  } s1_t;

  // Result queue status
  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               push;
  } fifo_stat_t;

endpackage

[src/bbg_stream_ifs.sv]
// Stream interfaces for the pixel input and the blur result channels.
`timescale 1ns / 1ps

interface bbg_pix_if import bbg_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             start_of_frame;

  modport source (output valid, output pixel, output start_of_frame, input ready);
  modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface bbg_res_if import bbg_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blurred;
  logic [POS_W-1:0] center_row;
  logic [POS_W-1:0] center_col;
  logic             last_of_frame;

  modport source (output valid, output blurred, output center_row, output center_col,
                  output last_of_frame, input ready);
  modport sink   (input valid, input blurred, input center_row, input center_col,
                  input last_of_frame, output ready);
endinterface

[src/bbg_line_mem.sv]
// Line store memory: both buffered rows packed into one entry, registered read.
`timescale 1ns / 1ps

module bbg_line_mem import bbg_pkg::*; #(
  parameter int DEPTH = MAX_SIZE_DEF,
  parameter int AW    = $clog2(MAX_SIZE_DEF)
) (
  input  logic              clk,
  input  logic [AW-1:0]     rd_addr,
  output logic [LINE_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [LINE_W-1:0] wr_data
);

  logic [LINE_W-1:0] mem [DEPTH];

  // Read-first: a read at the written address returns the old entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[src/bbg_window.sv]
// Window cells, line write-back, neighborhood sum and divide by nine.
`timescale 1ns / 1ps

module bbg_window import bbg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  s1_t               s1,
  input  logic [LINE_W-1:0] line_rd,   // {row r-2, row r-1} at this column
  output logic [LINE_W-1:0] line_wr,   // {row r-1, row r} for write-back
  output logic              push,
  output res_t              res
);

  logic [PIX_W-1:0] win_r [6];
  logic [PIX_W-1:0] top, mid;
  logic [SUM_W-1:0] sum;

  logic             s2_valid_r;
  logic [SUM_W-1:0] s2_sum_r;
  logic [POS_W-1:0] s2_row_r;
  logic [POS_W-1:0] s2_col_r;
  logic             s2_last_r;
  logic [PROD_W-1:0] prod;

  assign top     = line_rd[LINE_W-1:PIX_W];
  assign mid     = line_rd[PIX_W-1:0];
  assign line_wr = {mid, s1.px};

  // Nine-pixel sum
  assign sum = SUM_W'(win_r[0]) + SUM_W'(win_r[1]) + SUM_W'(win_r[2])
             + SUM_W'(win_r[3]) + SUM_W'(win_r[4]) + SUM_W'(win_r[5])
             + SUM_W'(top) + SUM_W'(mid) + SUM_W'(s1.px);

  // Shift window one column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1.valid) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= s1.px;
    end
  end

  // Sum stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1.valid && s1.emit;
    end
  end

  always_ff @(posedge clk) begin
    s2_sum_r  <= sum;
    s2_row_r  <= s1.center_row;
    s2_col_r  <= s1.center_col;
    s2_last_r <= s1.last;
  end

  // Reciprocal multiply
  assign prod = PROD_W'(s2_sum_r) * PROD_W'(RECIP_9);

  assign push              = s2_valid_r;
  assign res.blurred       = prod[RECIP_SH +: PIX_W];
  assign res.center_row    = s2_row_r;
  assign res.center_col    = s2_col_r;
  assign res.last_of_frame = s2_last_r;

endmodule

[src/bbg_res_fifo.sv]
// Result queue in front of the output channel.
`timescale 1ns / 1ps

module bbg_res_fifo import bbg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  res_t      push_data,
  bbg_res_if.source out_res,
  output fifo_stat_t stat
);

  res_t               q_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               pop;
  res_t               head;

  assign pop  = out_res.valid && out_res.ready;
  assign head = q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + FIFO_CW'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - FIFO_CW'(1);
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= FIFO_AW'(wr_ptr_r + FIFO_AW'(1));
      end
      if (pop) begin
        rd_ptr_r <= FIFO_AW'(rd_ptr_r + FIFO_AW'(1));
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_res.valid         = (count_r != '0);
  assign out_res.blurred       = head.blurred;
  assign out_res.center_row    = head.center_row;
  assign out_res.center_col    = head.center_col;
  assign out_res.last_of_frame = head.last_of_frame;

  assign stat.count = count_r;
  assign stat.push  = push;

endmodule

[src/box_blur_3x3_gray.sv]
// Top level of the 3x3 grey box blur: counters, line store, window and result queue.
`timescale 1ns / 1ps

// 3x3 box blur of a square grey image streamed in raster order.
// in_pix carries one pixel per transfer; start_of_frame puts that pixel at
// row 0, column 0. Frames may follow back to back without it.
// out_res carries one result per interior pixel: floor(sum / 9), the center
// row and column, and last_of_frame on the result centered at (size-2, size-2).
// cfg_we / cfg_wdata write the image side length; write it only while idle.
// Values below 3 or above MAX_SIZE are clamped.
// Throughput: one pixel per cycle while in_pix.ready is high. A result reaches
// out_res after the pixel below and right of its center has passed the line
// store read, window sum and divide by reciprocal multiply into the queue.
// The line store is a single-port-read, single-port-write memory with a
// forwarding register for a read that hits the entry written in the same cycle.
// Reset clears counters, window and queue; the size returns to 256. The line
// store is not cleared.
// When out_res stalls, the four-entry result queue fills and in_pix.ready
// drops once queued plus in-flight items reach four.
module box_blur_3x3_gray import bbg_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  bbg_pix_if.sink          in_pix,
  bbg_res_if.source        out_res
);

  localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int SW = $clog2(MAX_SIZE + 1);

  logic [CFG_W-1:0]  size_cfg_r;
  logic [AW-1:0]     row_r, col_r;
  logic [SW-1:0]     size_w;
  logic [31:0]       size32;
  logic [SW-1:0]     r_a, c_a, r_b, c_b, r_n, c_n;
  logic              accept;
  logic              emit, last;

  s1_t               s1_r, s1_nxt;
  logic [AW-1:0]     s1_addr_r;
  logic [AW-1:0]     rd_addr;
  logic [LINE_W-1:0] mem_rd, line_rd, line_wr;
  logic              fwd_r;
  logic [LINE_W-1:0] fwd_data_r;

  logic              push;
  res_t              push_data;
  fifo_stat_t        fstat;
  logic [FIFO_CW-1:0] in_flight;

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r <= SIZE_RESET;
    end else if (cfg_we) begin
      size_cfg_r <= cfg_wdata;
    end
  end

  // Clamp size into [3, MAX_SIZE]
  always_comb begin
    size32 = 32'(size_cfg_r);
    if (size32 < 32'(MIN_SIZE)) begin
      size32 = 32'(MIN_SIZE);
    end else if (size32 > 32'(MAX_SIZE)) begin
      size32 = 32'(MAX_SIZE);
    end
    size_w = SW'(size32);
  end

  // Position of the incoming pixel and the next position
  always_comb begin
    r_a = in_pix.start_of_frame ? '0 : SW'(row_r);
    c_a = in_pix.start_of_frame ? '0 : SW'(col_r);
    r_b = r_a;
    c_b = c_a;
    // counter left beyond a shrunk size
    if (c_a >= size_w) begin
      c_b = '0;
      r_b = r_a + SW'(1);
    end
    if (r_b >= size_w) begin
      r_b = '0;
    end
    c_n = c_b + SW'(1);
    r_n = r_b;
    if (c_n >= size_w) begin
      c_n = '0;
      r_n = r_b + SW'(1);
      if (r_n >= size_w) begin
        r_n = '0;
      end
    end
  end

  assign emit = (r_b >= SW'(2)) && (c_b >= SW'(2));
  assign last = (r_b == size_w - SW'(1)) && (c_b == size_w - SW'(1));

  // Credit against the result queue
  assign in_flight   = FIFO_CW'(s1_r.valid) + FIFO_CW'(fstat.push);
  assign in_pix.ready = (fstat.count + in_flight) < FIFO_CW'(FIFO_DEPTH);
  assign accept      = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= AW'(r_n);
      col_r <= AW'(c_n);
    end
  end

  // Read stage into the read-modify-write stage
  assign rd_addr = AW'(c_b);

  always_comb begin
    s1_nxt.valid      = accept;
    s1_nxt.emit       = emit;
    s1_nxt.last       = last;
    s1_nxt.px         = in_pix.pixel;
    s1_nxt.center_row = POS_W'(32'(r_b) - 32'd1);
    s1_nxt.center_col = POS_W'(32'(c_b) - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

  // Forward the entry written in the same cycle as the read of it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= s1_r.valid && (s1_addr_r == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r  <= rd_addr;
    fwd_data_r <= line_wr;
  end

  assign line_rd = fwd_r ? fwd_data_r : mem_rd;

  bbg_line_mem #(
    .DEPTH (MAX_SIZE),
    .AW    (AW)
  ) u_line_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (mem_rd),
    .wr_en   (s1_r.valid),
    .wr_addr (s1_addr_r),
    .wr_data (line_wr)
  );

  bbg_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1      (s1_r),
    .line_rd (line_rd),
    .line_wr (line_wr),
    .push    (push),
    .res     (push_data)
  );

  bbg_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_res   (out_res),
    .stat      (fstat)
  );

`ifndef NO_ASSERTIONS
  // Credit scheme must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && (fstat.count == FIFO_CW'(FIFO_DEPTH)) && !(out_res.valid && out_res.ready)))
    else $error("result queue overflow");

  // The final result of a frame sits on the diagonal
  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.last_of_frame) |-> (out_res.center_row == out_res.center_col))
    else $error("last_of_frame off the diagonal");

  // Forwarding only follows a write in the previous cycle
  a_fwd_cause: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> $past(s1_r.valid))
    else $error("forward without preceding write");
`endif

endmodule
